// ===== hdl/mca_pkg.sv =====
// ----------------------------------------------------------------------------
// mca_pkg: shared types and constants of the assignment solver
// Widths of the fixed fields, dual arithmetic width and register indexes.
// ----------------------------------------------------------------------------
package mca_pkg;

   localparam int MAX_ROWS_DEFAULT  = 16;
   localparam int COST_BITS_DEFAULT = 32;
   localparam int ROW_CAP           = 16;   // rows that results can report
   localparam int CFG_W             = 5;
   localparam int COST_W            = 32;
   localparam int TOTAL_W           = 48;
   localparam int DUAL_W            = 52;   // duals, slack and reduced costs

   localparam logic signed [DUAL_W-1:0] BIG_VALUE = DUAL_W'(64'sd1 <<< (DUAL_W - 2));

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic             start;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
   } mca_ctrl_type;

   typedef struct packed {
      logic                      done;
      logic signed [TOTAL_W-1:0] total;
   } mca_stat_type;

endpackage

// ===== hdl/mca_ram.sv =====
// ----------------------------------------------------------------------------
// mca_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/mca_core.sv =====
// ----------------------------------------------------------------------------
// mca_core: primal-dual Hungarian solve engine
// Column state (duals, slack, parent, match) lives in one RAM and is
// processed read-modify-write, one column at a time.
// ----------------------------------------------------------------------------
module mca_core #(
   parameter int MAX_ROWS  = mca_pkg::MAX_ROWS_DEFAULT,
   parameter int COST_BITS = mca_pkg::COST_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mca_pkg::mca_ctrl_type              ctrl,
   output mca_pkg::mca_stat_type              stat,
   output logic [$clog2(MAX_ROWS*MAX_ROWS)-1:0] cost_raddr,
   input  logic [((COST_BITS < 32) ? COST_BITS : 32)-1:0] cost_rdata,
   input  logic [$clog2((MAX_ROWS < 16) ? MAX_ROWS : 16)-1:0] emit_row,
   output logic [$clog2((MAX_ROWS < 16) ? MAX_ROWS : 16)-1:0] emit_col
);
   import mca_pkg::*;

   localparam int ROW_LIM = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;
   localparam int JW      = $clog2(ROW_LIM + 1);
   localparam int RW      = $clog2(ROW_LIM);
   localparam int CW      = (COST_BITS < 32) ? COST_BITS : 32;
   localparam int CAW     = $clog2(MAX_ROWS * MAX_ROWS);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_INIT    = 4'd1;
   localparam logic [3:0] ST_PHASE   = 4'd2;
   localparam logic [3:0] ST_J0_RD   = 4'd3;
   localparam logic [3:0] ST_J0_GOT  = 4'd4;
   localparam logic [3:0] ST_SC_RD   = 4'd5;
   localparam logic [3:0] ST_SC_CALC = 4'd6;
   localparam logic [3:0] ST_SC_WR   = 4'd7;
   localparam logic [3:0] ST_UP_RD   = 4'd8;
   localparam logic [3:0] ST_UP_WR   = 4'd9;
   localparam logic [3:0] ST_AUG_RD  = 4'd10;
   localparam logic [3:0] ST_AUG_P   = 4'd11;
   localparam logic [3:0] ST_AUG_WR  = 4'd12;
   localparam logic [3:0] ST_FIN_RD  = 4'd13;
   localparam logic [3:0] ST_FIN_GOT = 4'd14;
   localparam logic [3:0] ST_FIN_ADD = 4'd15;

   typedef struct packed {
      logic signed [DUAL_W-1:0] u;       // dual of the row matched here
      logic signed [DUAL_W-1:0] v;       // column dual
      logic signed [DUAL_W-1:0] slack;
      logic [JW-1:0]            parent;
      logic [JW-1:0]            match;
   } col_entry_type;

   logic [3:0]               state_ff, state_in;
   logic [JW-1:0]            n_ff, n_in, c_ff, c_in;
   logic [JW-1:0]            i_ff, i_in, j_ff, j_in;
   logic [JW-1:0]            j0_ff, j0_in, j1_ff, j1_in, cur_ff, cur_in;
   logic [CAW-1:0]           base_ff, base_in;
   logic signed [DUAL_W-1:0] u0_ff, u0_in, delta_ff, delta_in, red_ff, red_in;
   logic signed [TOTAL_W-1:0] sum_ff, sum_in;
   logic [ROW_LIM:0]         reached_ff, reached_in, sv_ff, sv_in;
   logic [RW-1:0]            rowm_ff [ROW_LIM];
   logic                     rowm_we;
   logic [RW-1:0]            rowm_idx, rowm_val;
   col_entry_type            ent_ff, ent_in;
   logic                     done_ff, done_in;

   logic                     col_we;
   logic [JW-1:0]            col_waddr, col_raddr;
   col_entry_type            col_wdata, col_rdata;
   logic signed [DUAL_W-1:0] cost_ext, slk;
   logic [CAW-1:0]           addr_c;

   mca_ram #(.WIDTH($bits(col_entry_type)), .DEPTH(ROW_LIM + 1)) u_col_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_addr (col_raddr),
      .rd_data (col_rdata)
   );

   assign cost_ext = {{(DUAL_W - CW){cost_rdata[CW-1]}}, cost_rdata};
   assign emit_col = rowm_ff[emit_row];
   assign stat.done  = done_ff;
   assign stat.total = sum_ff;

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      c_in       = c_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      j0_in      = j0_ff;
      j1_in      = j1_ff;
      cur_in     = cur_ff;
      base_in    = base_ff;
      u0_in      = u0_ff;
      delta_in   = delta_ff;
      red_in     = red_ff;
      sum_in     = sum_ff;
      reached_in = reached_ff;
      sv_in      = sv_ff;
      ent_in     = ent_ff;
      done_in    = 1'b0;
      col_we     = 1'b0;
      col_waddr  = j_ff;
      col_wdata  = ent_ff;
      col_raddr  = j_ff;
      cost_raddr = CAW'(int'(base_ff) + int'(j_ff) - 1);
      rowm_we    = 1'b0;
      rowm_idx   = RW'(int'(col_rdata.match) - 1);
      rowm_val   = RW'(int'(j_ff) - 1);
      slk        = BIG_VALUE;
      addr_c     = CAW'((int'(col_rdata.match) - 1) * int'(c_ff) + int'(j_ff) - 1);

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               n_in     = JW'(ctrl.rows);
               c_in     = JW'(ctrl.cols);
               j_in     = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            col_we    = 1'b1;
            col_wdata = '0;
            if (j_ff == n_ff) begin
               i_in     = JW'(1);
               state_in = ST_PHASE;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         ST_PHASE: begin
            // Column zero carries the row being inserted, with a zero dual.
            col_we          = 1'b1;
            col_waddr       = '0;
            col_wdata       = '0;
            col_wdata.match = i_ff;
            reached_in      = '0;
            sv_in           = '0;
            j0_in           = '0;
            state_in        = ST_J0_RD;
         end
         ST_J0_RD: begin
            col_raddr = j0_ff;
            state_in  = ST_J0_GOT;
         end
         ST_J0_GOT: begin
            if (col_rdata.match == '0) begin
               cur_in   = j0_ff;
               state_in = ST_AUG_RD;
            end else begin
               u0_in      = col_rdata.u;
               base_in    = CAW'((int'(col_rdata.match) - 1) * int'(c_ff));
               reached_in[j0_ff] = 1'b1;
               delta_in   = BIG_VALUE;
               j1_in      = '0;
               j_in       = JW'(1);
               state_in   = ST_SC_RD;
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_CALC;
         end
         ST_SC_CALC: begin
            ent_in   = col_rdata;
            red_in   = ((j_ff > c_ff) ? '0 : cost_ext) - u0_ff - col_rdata.v;
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            if (!reached_ff[j_ff]) begin
               slk       = sv_ff[j_ff] ? ent_ff.slack : BIG_VALUE;
               col_wdata = ent_ff;
               if (red_ff < slk) begin
                  slk              = red_ff;
                  col_wdata.parent = j0_ff;
               end
               col_wdata.slack = slk;
               col_we          = 1'b1;
               sv_in[j_ff]     = 1'b1;
               if (slk < delta_ff) begin
                  delta_in = slk;
                  j1_in    = j_ff;
               end
            end
            if (j_ff == n_ff) begin
               j_in     = '0;
               state_in = ST_UP_RD;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_UP_RD: begin
            state_in = ST_UP_WR;
         end
         ST_UP_WR: begin
            col_we    = 1'b1;
            col_wdata = col_rdata;
            if (reached_ff[j_ff]) begin
               col_wdata.u = col_rdata.u + delta_ff;
               col_wdata.v = col_rdata.v - delta_ff;
            end else begin
               col_wdata.slack = col_rdata.slack - delta_ff;
            end
            if (j_ff == n_ff) begin
               j0_in    = j1_ff;
               state_in = ST_J0_RD;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = ST_UP_RD;
            end
         end
         ST_AUG_RD: begin
            col_raddr = cur_ff;
            state_in  = ST_AUG_P;
         end
         ST_AUG_P: begin
            ent_in    = col_rdata;
            col_raddr = col_rdata.parent;
            state_in  = ST_AUG_WR;
         end
         ST_AUG_WR: begin
            // The row and its dual move one column back along the path.
            col_we          = 1'b1;
            col_waddr       = cur_ff;
            col_wdata       = ent_ff;
            col_wdata.match = col_rdata.match;
            col_wdata.u     = col_rdata.u;
            cur_in          = ent_ff.parent;
            if (ent_ff.parent != '0) begin
               state_in = ST_AUG_RD;
            end else if (i_ff == n_ff) begin
               j_in     = JW'(1);
               sum_in   = '0;
               state_in = ST_FIN_RD;
            end else begin
               i_in     = i_ff + JW'(1);
               state_in = ST_PHASE;
            end
         end
         ST_FIN_RD: begin
            state_in = ST_FIN_GOT;
         end
         ST_FIN_GOT: begin
            rowm_we    = 1'b1;
            cost_raddr = addr_c;
            if (j_ff <= c_ff) begin
               state_in = ST_FIN_ADD;
            end else if (j_ff == n_ff) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = ST_FIN_RD;
            end
         end
         ST_FIN_ADD: begin
            sum_in = sum_ff + TOTAL_W'(cost_ext);
            if (j_ff == n_ff) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = ST_FIN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff       <= n_in;
      c_ff       <= c_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      j0_ff      <= j0_in;
      j1_ff      <= j1_in;
      cur_ff     <= cur_in;
      base_ff    <= base_in;
      u0_ff      <= u0_in;
      delta_ff   <= delta_in;
      red_ff     <= red_in;
      sum_ff     <= sum_in;
      reached_ff <= reached_in;
      sv_ff      <= sv_in;
      ent_ff     <= ent_in;
      if (rowm_we) begin
         rowm_ff[rowm_idx] <= rowm_val;
      end
   end

endmodule

// ===== hdl/min_cost_assignment_solver.sv =====
// ----------------------------------------------------------------------------
// min_cost_assignment_solver: minimum-cost assignment (Hungarian method)
// Loads a cost matrix row by row, solves it and reports one result per row.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  req_*     in         one Q16.16 cost entry per transaction, last_entry ends
//  rsp_*     out        one row assignment per transaction, total on each
//  csr_*     in         register writes: 0 rows_in_use, 1 cols_in_use
//
// Loading accepts one entry per cycle. The last_entry transaction starts the solve
// with the input stalled: per row i, a setup step, up to i search steps and a walk
// back along the path, one column at a time through the column-state RAM, and
// then a readout of all rows. Results leave one per cycle unless rsp_ready stalls
// them. Reset restores 16 rows and 16 columns.
//
module min_cost_assignment_solver #(
   parameter int MAX_ROWS  = mca_pkg::MAX_ROWS_DEFAULT,
   parameter int COST_BITS = mca_pkg::COST_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [mca_pkg::COST_W-1:0]  req_cost_value,
   input  logic                               req_last_entry,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [3:0]                         rsp_row_index,
   output logic [3:0]                         rsp_assigned_column,
   output logic                               rsp_is_assigned,
   output logic signed [mca_pkg::TOTAL_W-1:0] rsp_total_cost,
   output logic                               rsp_last_row,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [mca_pkg::CFG_W-1:0]          csr_wdata
);
   import mca_pkg::*;

   localparam int ROW_LIM = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;
   localparam int RW      = $clog2(ROW_LIM);
   localparam int CW      = (COST_BITS < 32) ? COST_BITS : 32;
   localparam int DEPTH   = MAX_ROWS * MAX_ROWS;
   localparam int CAW     = $clog2(DEPTH);
   localparam int LPW     = $clog2(DEPTH + 1);

   localparam logic [1:0] T_LOAD  = 2'd0;
   localparam logic [1:0] T_SOLVE = 2'd1;
   localparam logic [1:0] T_EMIT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] rows_ff, cols_ff;
   logic [CFG_W-1:0] n_eff, c_eff;
   logic [LPW-1:0]   load_pos_ff, load_pos_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             req_fire, store_en;
   logic [CAW-1:0]   cost_raddr;
   logic [CW-1:0]    cost_rdata;
   logic [RW-1:0]    emit_col;
   mca_ctrl_type     ctrl;
   mca_stat_type     stat;
   logic             rsp_valid_ff, rsp_valid_in, rsp_load;

   // Effective sizes: rows within 1..ROW_LIM, columns within 1..rows.
   always_comb begin
      n_eff = rows_ff;
      if (n_eff == '0) begin
         n_eff = CFG_W'(1);
      end
      if (int'(n_eff) > ROW_LIM) begin
         n_eff = CFG_W'(ROW_LIM);
      end
      c_eff = cols_ff;
      if (c_eff == '0) begin
         c_eff = CFG_W'(1);
      end
      if (c_eff > n_eff) begin
         c_eff = n_eff;
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == T_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign store_en  = req_fire && (int'(load_pos_ff) < int'(n_eff) * int'(c_eff));

   assign ctrl.start = req_fire && req_last_entry;
   assign ctrl.rows  = n_eff;
   assign ctrl.cols  = c_eff;

   mca_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cost_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (CAW'(load_pos_ff)),
      .wr_data (req_cost_value[CW-1:0]),
      .rd_addr (cost_raddr),
      .rd_data (cost_rdata)
   );

   mca_core #(.MAX_ROWS(MAX_ROWS), .COST_BITS(COST_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .cost_raddr (cost_raddr),
      .cost_rdata (cost_rdata),
      .emit_row   (row_ff),
      .emit_col   (emit_col)
   );

   // A new result may enter the output register whenever it is empty or
   // its transaction completes in this cycle.
   assign rsp_load = (state_ff == T_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         T_LOAD: begin
            if (store_en) begin
               load_pos_in = load_pos_ff + LPW'(1);
            end
            if (ctrl.start) begin
               load_pos_in = '0;
               state_in    = T_SOLVE;
            end
         end
         T_SOLVE: begin
            row_in = '0;
            if (stat.done) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               row_in       = row_ff + RW'(1);
               if (int'(row_ff) == int'(ctrl.rows) - 1) begin
                  state_in = T_LOAD;
               end
            end
         end
         default: begin
            state_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         load_pos_ff  <= '0;
         rows_ff      <= CFG_W'(16);
         cols_ff      <= CFG_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS: rows_ff <= csr_wdata;
               REG_COLS: cols_ff <= csr_wdata;
               default:  rows_ff <= rows_ff;
            endcase
         end
      end
      row_ff <= row_in;
      if (rsp_load) begin
         rsp_row_index       <= 4'(row_ff);
         rsp_is_assigned     <= (CFG_W'(emit_col) < ctrl.cols);
         rsp_assigned_column <= (CFG_W'(emit_col) < ctrl.cols) ? 4'(emit_col) : 4'd0;
         rsp_total_cost      <= stat.total;
         rsp_last_row        <= (int'(row_ff) == int'(ctrl.rows) - 1);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== verif/min_cost_assignment_solver_tb.sv =====
// ----------------------------------------------------------------------------
// min_cost_assignment_solver_tb: self-checking bench of the assignment solver
// Cost matrices of many shapes are streamed in under random idling. An
// in-bench Hungarian solver predicts every row result, and the bench checks
// each result transaction field by field as it leaves the block.
// ----------------------------------------------------------------------------
module min_cost_assignment_solver_tb;
   import mca_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS_MAX = 16;

   typedef struct {
      logic signed [COST_W-1:0] cost;
      logic                     last;
   } entry_type;

   typedef struct {
      logic [3:0]                row;
      logic [3:0]                col;
      logic                      assigned;
      logic signed [TOTAL_W-1:0] total;
      logic                      last_row;
   } row_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COST_W-1:0]  req_cost_value = '0;
   logic                      req_last_entry = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [3:0]                rsp_row_index;
   logic [3:0]                rsp_assigned_column;
   logic                      rsp_is_assigned;
   logic signed [TOTAL_W-1:0] rsp_total_cost;
   logic                      rsp_last_row;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_index = REG_ROWS;
   logic [CFG_W-1:0]          csr_wdata = '0;

   // Entries waiting to be sent, and row results still owed by the block.
   entry_type      pending_entries[$];
   row_result_type owed_rows[$];

   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   int  mismatch_count = 0;

   // Predictor state: register copies, the cost store and the load pointer.
   logic [CFG_W-1:0] rows_reg = 5'd16;
   logic [CFG_W-1:0] cols_reg = 5'd16;
   longint           cost_mem[0:255];
   int               load_ptr = 0;

   // Generator-side view of which store entries hold a value, so that an
   // early end of matrix never makes the block read a never-written entry.
   bit               gen_written[0:255];
   int               gen_ptr = 0;

   always #10 clock = ~clock;

   min_cost_assignment_solver uut (.*);

   function automatic int eff_rows();
      if (rows_reg < 1) return 1;
      if (rows_reg > ROWS_MAX) return ROWS_MAX;
      return rows_reg;
   endfunction

   function automatic int eff_cols(int n);
      if (cols_reg < 1) return 1;
      if (cols_reg > n) return n;
      return cols_reg;
   endfunction

   // Appends one entry to the send queue.
   task automatic add_entry(logic signed [COST_W-1:0] cost, logic last);
      entry_type e;
      e.cost = cost;
      e.last = last;
      pending_entries.insert(pending_entries.size(), e);
   endtask

   // Shortest-augmenting-path Hungarian method on the padded n x n matrix.
   // Dummy columns (index >= c) cost zero. Queues the n row results.
   task automatic solve_and_predict(int n, int c);
      longint u[0:ROWS_MAX], v[0:ROWS_MAX], slack[0:ROWS_MAX];
      int     colm[0:ROWS_MAX], parent[0:ROWS_MAX], rowm[0:ROWS_MAX];
      bit     seen[0:ROWS_MAX];
      longint big, delta, red, sum;
      int     i, j, j0, j1, i0, col;
      row_result_type res;
      big = 64'sh1FFF_FFFF_FFFF_FFFF;
      for (j = 0; j <= n; j++) begin
         u[j] = 0; v[j] = 0; colm[j] = 0; parent[j] = 0;
      end
      for (i = 1; i <= n; i++) begin
         j0 = 0;
         colm[0] = i;
         for (j = 0; j <= n; j++) begin
            slack[j] = big; seen[j] = 0;
         end
         do begin
            i0 = colm[j0];
            j1 = 0;
            delta = big;
            seen[j0] = 1;
            for (j = 1; j <= n; j++) begin
               if (!seen[j]) begin
                  red = ((j - 1) < c ? cost_mem[(i0 - 1) * c + j - 1] : 0) - u[i0] - v[j];
                  if (red < slack[j]) begin
                     slack[j] = red; parent[j] = j0;
                  end
                  if (slack[j] < delta) begin
                     delta = slack[j]; j1 = j;
                  end
               end
            end
            for (j = 0; j <= n; j++) begin
               if (seen[j]) begin
                  u[colm[j]] += delta;
                  v[j] -= delta;
               end else begin
                  slack[j] -= delta;
               end
            end
            j0 = j1;
         end while (colm[j0] != 0);
         do begin
            j1 = parent[j0];
            colm[j0] = colm[j1];
            j0 = j1;
         end while (j0 != 0);
      end
      for (j = 1; j <= n; j++) rowm[colm[j]] = j;
      sum = 0;
      for (i = 1; i <= n; i++) begin
         col = rowm[i] - 1;
         if (col < c) sum += cost_mem[(i - 1) * c + col];
      end
      for (i = 0; i < n; i++) begin
         col = rowm[i + 1] - 1;
         res.row      = i[3:0];
         res.assigned = (col < c);
         res.col      = (col < c) ? col[3:0] : 4'd0;
         res.total    = sum[TOTAL_W-1:0];
         res.last_row = (i == n - 1);
         owed_rows.insert(owed_rows.size(), res);
      end
   endtask

   // Driver: presents queued entries; an accepted entry updates the predictor.
   always @(posedge clock) begin : entry_driver
      logic      next_valid;
      entry_type e;
      int        n, c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            n = eff_rows();
            c = eff_cols(n);
            if (load_ptr < n * c) begin
               cost_mem[load_ptr] = req_cost_value;
               load_ptr++;
            end
            if (req_last_entry) begin
               solve_and_predict(n, c);
               load_ptr = 0;
            end
            next_valid = 1'b0;
         end
         if (!next_valid && pending_entries.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            e = pending_entries.pop_front();
            req_cost_value <= e.cost;
            req_last_entry <= e.last;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: random back-pressure, and each result transaction is checked
   // against the oldest owed row result.
   always @(posedge clock) begin : result_monitor
      row_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rows.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: row %0d col %0d", rsp_row_index,
                           rsp_assigned_column);
            end else begin
               want = owed_rows.pop_front();
               if (rsp_row_index !== want.row || rsp_assigned_column !== want.col ||
                   rsp_is_assigned !== want.assigned || rsp_total_cost !== want.total ||
                   rsp_last_row !== want.last_row) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: got row %0d col %0d asg %0b total %0d last %0b, %s",
                              rsp_row_index, rsp_assigned_column, rsp_is_assigned,
                              rsp_total_cost, rsp_last_row,
                              $sformatf("want row %0d col %0d asg %0b total %0d last %0b",
                                        want.row, want.col, want.assigned, want.total,
                                        want.last_row));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Waits until the block has sent every owed result and sits idle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_entries.size() != 0 || owed_rows.size() != 0 || req_valid);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_ROWS) rows_reg = value;
      else cols_reg = value;
   endtask

   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom();
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   // Queues one matrix. Style 0 ends on the final entry, style 1 ends after one to
   // three surplus entries, style 2 ends early where the store allows it.
   task automatic queue_matrix(int style, bit zeros);
      int        n, c, total, count, k, p;
      bit        all_known;
      entry_type e;
      n = eff_rows();
      c = eff_cols(n);
      total = n * c;
      all_known = 1;
      for (p = 0; p < total; p++) if (!gen_written[p]) all_known = 0;
      if (style == 2 && (!all_known || total < 2)) style = 0;
      case (style)
         1:       count = total + $urandom_range(1, 3);
         2:       count = $urandom_range(1, total - 1);
         default: count = total;
      endcase
      for (k = 0; k < count; k++) begin
         e.cost = zeros ? '0 : pick_cost();
         e.last = (k == count - 1);
         if (gen_ptr < total) begin
            gen_written[gen_ptr] = 1;
            gen_ptr++;
         end
         pending_entries.insert(pending_entries.size(), e);
      end
      gen_ptr = 0;
   endtask

   initial begin : stimulus
      int phase, sent, target, rows_pick;
      for (int p = 0; p < 256; p++) gen_written[p] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: single-entry extremes, clamping of both registers,
      // an all-tie matrix with surplus entries, and an early end of matrix.
      write_reg(REG_ROWS, 5'd0);
      write_reg(REG_COLS, 5'd31);
      add_entry(32'h7FFF_FFFF, 1'b1);
      add_entry(32'h8000_0000, 1'b1);
      wait_idle();
      write_reg(REG_ROWS, 5'd3);
      queue_matrix(1, 1'b1);
      wait_idle();
      write_reg(REG_ROWS, 5'd2);
      write_reg(REG_COLS, 5'd1);
      add_entry(32'h8000_0000, 1'b0);
      add_entry(32'h7FFF_FFFF, 1'b1);
      queue_matrix(2, 1'b0);
      wait_idle();
      write_reg(REG_ROWS, 5'd31);
      write_reg(REG_COLS, 5'd0);
      queue_matrix(0, 1'b0);
      wait_idle();

      // Random part, four idling phases.
      sent = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         target = sent + 90;
         while (sent < target) begin
            // Full-height matrices are kept narrow to hold the item count down.
            rows_pick = ($urandom_range(9) == 0) ? $urandom_range(16, 31)
                                                 : $urandom_range(0, 6);
            write_reg(REG_ROWS, 5'(rows_pick));
            write_reg(REG_COLS, (rows_pick >= 16) ? 5'($urandom_range(0, 2))
                                                  : 5'($urandom_range(0, 31)));
            for (int m = 0; m < 3; m++) begin
               sent += pending_entries.size();
               queue_matrix($urandom_range(5) < 3 ? 0 : $urandom_range(1, 2), 1'b0);
               sent -= pending_entries.size();
               sent += 2 * pending_entries.size();
               wait_idle();
               sent -= pending_entries.size();
            end
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && owed_rows.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
